FILE: hdl/bdrc_pkg.sv
`default_nettype none
package bdrc_pkg;

  // Field and register width
  localparam int DATA_W = 17;

  // Default number of fractional bits
  localparam int FRAC_BITS_DEF = 16;

  // Register reset values
  localparam logic [DATA_W-1:0] DEADZONE_RESET = 17'd0;
  localparam logic [DATA_W-1:0] KNEE_RESET     = 17'd39322;

  // Register index
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE = 1'b0,
    CFG_KNEE     = 1'b1
  } cfg_idx_t;

endpackage
`default_nettype wire

FILE: hdl/bezier_deadzone_response_curve.sv
`default_nettype none
// Pipeline: stage 0, stage 1, the discriminant register, RW = max(17, FRAC_BITS+1) + 4
// square-root stages, the divider setup register, QB = FRAC_BITS + 2 divider stages, then the t,
// square, weight and output registers. Throughput: one request per cycle; busy stays low.
// The receiver cannot stall: each result is shown for one cycle with out_strobe.
// Reset (synchronous, rst_n low) clears all valid bits and sets deadzone to 0 and
// curve_knee to 39322.
module bezier_deadzone_response_curve #(
  parameter int FRAC_BITS = bdrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bdrc_pkg::DATA_W-1:0]    in_magnitude,
  output logic                                out_strobe,
  output logic [bdrc_pkg::DATA_W-1:0]         out_response,
  output logic                                out_clamped,
  input  wire logic                           cfg_we,
  input  wire logic [bdrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdrc_pkg::DATA_W-1:0]    cfg_data
);
  import bdrc_pkg::*;

  localparam int IW   = DATA_W;
  localparam int MW   = (FRAC_BITS + 1 > IW) ? FRAC_BITS + 1 : IW;
  localparam int BW   = MW + 3;
  localparam int PW   = 2 * BW;
  localparam int DW   = 2 * BW + 3;
  localparam int RW   = BW + 1;
  localparam int RMW  = RW + 2;
  localparam int NSW  = RW + 2;
  localparam int DVW  = BW + 1;
  localparam int QB   = FRAC_BITS + 2;
  localparam int NW   = NSW + FRAC_BITS;
  localparam int CW   = ((NW > DVW + QB) ? NW : DVW + QB) + 1;
  localparam int TW   = FRAC_BITS + 1;
  localparam int YW   = BW + TW + 2;
  localparam int LAT  = RW + QB + 8;

  localparam logic signed [BW-1:0] ONE_S  = BW'(1) << FRAC_BITS;
  localparam logic [QB-1:0]        ONE_Q  = QB'(1) << FRAC_BITS;
  localparam logic [TW-1:0]        ONE_T  = TW'(1) << FRAC_BITS;
  localparam logic signed [YW-1:0] ONE_Y  = YW'(1) << FRAC_BITS;
  localparam logic [IW-1:0]        ONE_O  = IW'(ONE_T);

  typedef struct packed {
    logic          below;
    logic          clamp;
    logic [IW-1:0] xd;
  } side_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  logic [IW-1:0] dz_r, kn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DEADZONE_RESET;
      kn_r <= KNEE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEADZONE: dz_r <= cfg_data;
        CFG_KNEE:     kn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Curve coefficients; the user must hold them static while requests are in flight (unenforced)
  logic signed [BW-1:0] d_s, k_s, ax_s, bx_s, ay_s, by_s;
  logic                 lin, degen;
  assign d_s   = $signed(BW'(dz_r));
  assign k_s   = $signed(BW'(kn_r));
  assign ax_s  = d_s - (k_s <<< 1) + ONE_S;
  assign bx_s  = (k_s - d_s) <<< 1;
  assign ay_s  = (k_s <<< 1) - ONE_S;
  assign by_s  = (ONE_S - k_s) <<< 1;
  assign lin   = (ax_s == '0);
  assign degen = lin && (bx_s == '0);

  // Valid bits of all stages
  logic                  s0_v_r, s1_v_r, p_v_r, t_v_r, m1_v_r, m2_v_r, out_v_r;
  logic                  sq_v_r [0:RW];
  logic                  dv_v_r [0:QB];

  // Stage 0: capture request
  logic [IW-1:0] s0_x_r;
  always_ff @(posedge clk) begin
    s0_x_r <= in_magnitude;
  end

  // Stage 1: products of the discriminant
  logic signed [BW-1:0] x_s, c_s;
  logic signed [PW-1:0] s1_bb_r, s1_ac_r;
  logic                 s1_below_r;
  logic [IW-1:0]        s1_xd_r;
  assign x_s = $signed(BW'(s0_x_r));
  assign c_s = d_s - x_s;
  always_ff @(posedge clk) begin
    s1_bb_r    <= bx_s * bx_s;
    s1_ac_r    <= ax_s * c_s;
    s1_below_r <= (s0_x_r < dz_r);
    s1_xd_r    <= s0_x_r - dz_r;
  end

  // Stage 2: discriminant, floored at zero
  logic signed [DW-1:0] disc_s;
  logic                 disc_neg;
  assign disc_s   = DW'(s1_bb_r) - (DW'(s1_ac_r) <<< 2);
  assign disc_neg = disc_s[DW-1];

  logic [RMW-1:0]  sq_rem_r  [0:RW];
  logic [RW-1:0]   sq_root_r [0:RW];
  logic [2*RW-1:0] sq_d_r    [0:RW];
  side_t           sq_sb_r   [0:RW];

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_d_r[0]    <= disc_neg ? '0 : disc_s[DW-2:0];
    sq_sb_r[0]   <= '{below: s1_below_r, clamp: disc_neg, xd: s1_xd_r};
  end

  // Square root: one root bit per stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [RMW-1:0] cur, trial, rem_nxt;
    logic [RW-1:0]  root_nxt;
    always_comb begin
      cur   = {sq_rem_r[j][RMW-3:0], sq_d_r[j][2*RW-1 -: 2]};
      trial = {sq_root_r[j], 2'b01};
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {sq_root_r[j][RW-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {sq_root_r[j][RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      sq_rem_r[j+1]  <= rem_nxt;
      sq_root_r[j+1] <= root_nxt;
      sq_d_r[j+1]    <= sq_d_r[j] << 2;
      sq_sb_r[j+1]   <= sq_sb_r[j];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end
  end

  // Divider setup: numerator and denominator in sign and magnitude
  logic signed [NSW-1:0] num_s;
  logic signed [DVW-1:0] den_s;
  logic [NSW-1:0]        nmag;
  logic [DVW-1:0]        dmag;
  logic [CW-1:0]         n_c, d_c;
  always_comb begin
    num_s = lin ? $signed(NSW'(sq_sb_r[RW].xd))
                : $signed(NSW'(sq_root_r[RW])) - NSW'(bx_s);
    den_s = lin ? DVW'(bx_s) : (DVW'(ax_s) <<< 1);
    nmag  = num_s[NSW-1] ? NSW'(-num_s) : NSW'(num_s);
    dmag  = den_s[DVW-1] ? DVW'(-den_s) : DVW'(den_s);
    n_c   = CW'({nmag, {FRAC_BITS{1'b0}}});
    d_c   = CW'(dmag);
  end

  logic [CW-1:0] dv_rem_r [0:QB];
  logic [CW-1:0] dv_den_r [0:QB];
  logic [QB-1:0] dv_q_r   [0:QB];
  logic          dv_neg_r [0:QB];
  logic          dv_ovf_r [0:QB];
  side_t         dv_sb_r  [0:QB];

  always_ff @(posedge clk) begin
    dv_rem_r[0] <= n_c;
    dv_den_r[0] <= d_c;
    dv_q_r[0]   <= '0;
    dv_neg_r[0] <= num_s[NSW-1] ^ den_s[DVW-1];
    dv_ovf_r[0] <= (n_c >= (d_c << QB));
    dv_sb_r[0]  <= sq_sb_r[RW];
  end

  // Restoring divider: one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [CW-1:0] sh, rem_nxt;
    logic          qbit;
    always_comb begin
      sh = dv_den_r[j] << (QB - 1 - j);
      if (dv_rem_r[j] >= sh) begin
        rem_nxt = dv_rem_r[j] - sh;
        qbit    = 1'b1;
      end else begin
        rem_nxt = dv_rem_r[j];
        qbit    = 1'b0;
      end
    end
    always_ff @(posedge clk) begin
      dv_rem_r[j+1] <= rem_nxt;
      dv_den_r[j+1] <= dv_den_r[j];
      dv_q_r[j+1]   <= {dv_q_r[j][QB-2:0], qbit};
      dv_neg_r[j+1] <= dv_neg_r[j];
      dv_ovf_r[j+1] <= dv_ovf_r[j];
      dv_sb_r[j+1]  <= dv_sb_r[j];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end
  end

  // Saturate t to [0, 1]
  logic [TW-1:0] t_nxt, t_r;
  logic          tc_nxt, t_clamp_r, t_below_r;
  always_comb begin
    t_nxt  = dv_q_r[QB][TW-1:0];
    tc_nxt = 1'b0;
    if (dv_neg_r[QB] && (dv_ovf_r[QB] || dv_q_r[QB] != '0)) begin
      t_nxt  = '0;
      tc_nxt = 1'b1;
    end else if (!dv_neg_r[QB] && (dv_ovf_r[QB] || dv_q_r[QB] > ONE_Q)) begin
      t_nxt  = ONE_T;
      tc_nxt = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    t_clamp_r <= dv_sb_r[QB].clamp | tc_nxt;
    t_below_r <= dv_sb_r[QB].below;
  end

  // Square t
  logic [2*TW-1:0] m1_tt_r;
  logic [TW-1:0]   m1_t_r;
  logic            m1_clamp_r, m1_below_r;
  always_ff @(posedge clk) begin
    m1_tt_r    <= t_r * t_r;
    m1_t_r     <= t_r;
    m1_clamp_r <= t_clamp_r;
    m1_below_r <= t_below_r;
  end

  // Weight the terms of y
  logic [TW-1:0]        tt;
  logic signed [YW-1:0] p1_nxt, p2_nxt, m2_p1_r, m2_p2_r;
  logic                 m2_clamp_r, m2_below_r;
  assign tt     = m1_tt_r[FRAC_BITS +: TW];
  assign p1_nxt = YW'(ay_s) * $signed(YW'(tt));
  assign p2_nxt = YW'(by_s) * $signed(YW'(m1_t_r));
  always_ff @(posedge clk) begin
    m2_p1_r    <= p1_nxt;
    m2_p2_r    <= p2_nxt;
    m2_clamp_r <= m1_clamp_r;
    m2_below_r <= m1_below_r;
  end

  // Sum, scale and saturate y; apply the dead zone and flat-curve cases
  logic signed [YW-1:0] y_s;
  logic [TW-1:0]        y_sat;
  logic                 yc;
  logic [IW-1:0]        resp_nxt, out_response_r;
  logic                 clamp_nxt, out_clamped_r;
  always_comb begin
    y_s   = (m2_p1_r + m2_p2_r) >>> FRAC_BITS;
    y_sat = y_s[TW-1:0];
    yc    = 1'b0;
    if (y_s < 0) begin
      y_sat = '0;
      yc    = 1'b1;
    end else if (y_s > ONE_Y) begin
      y_sat = ONE_T;
      yc    = 1'b1;
    end
    if (m2_below_r) begin
      resp_nxt  = '0;
      clamp_nxt = 1'b0;
    end else if (degen) begin
      resp_nxt  = ONE_O;
      clamp_nxt = 1'b0;
    end else begin
      resp_nxt  = IW'(y_sat);
      clamp_nxt = m2_clamp_r | yc;
    end
  end
  always_ff @(posedge clk) begin
    out_response_r <= resp_nxt;
    out_clamped_r  <= clamp_nxt;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r    <= 1'b0;
      s1_v_r    <= 1'b0;
      sq_v_r[0] <= 1'b0;
      p_v_r     <= 1'b0;
      dv_v_r[0] <= 1'b0;
      t_v_r     <= 1'b0;
      m1_v_r    <= 1'b0;
      m2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      s0_v_r    <= accept;
      s1_v_r    <= s0_v_r;
      sq_v_r[0] <= s1_v_r;
      p_v_r     <= sq_v_r[RW];
      dv_v_r[0] <= sq_v_r[RW];
      t_v_r     <= dv_v_r[QB];
      m1_v_r    <= t_v_r;
      m2_v_r    <= m1_v_r;
      out_v_r   <= m2_v_r;
    end
  end

  assign out_strobe   = out_v_r;
  assign out_response = out_response_r;
  assign out_clamped  = out_clamped_r;

  // Every request yields one result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_strobe)
    else $error("result missing after request");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT))
    else $error("result without request");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    t_v_r |-> (t_r <= ONE_T))
    else $error("curve parameter out of range");

  // p_v_r marks the divider setup stage
  a_div_setup: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> dv_v_r[0])
    else $error("divider setup lost a request");

endmodule
`default_nettype wire
